>>> src/ccc_pkg.sv
// Shared types and codes for the cut component classifier.
`timescale 1ns / 1ps
`default_nettype none
package ccc_pkg;
    typedef logic [8:0] slot_t;
    typedef logic [7:0] vertex_t;

    localparam int CUT_PORTS = 4;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_EDGE_COUNT   = 1'b1;
endpackage
`default_nettype wire

>>> src/ccc_edge_filter.sv
// Decides whether a stored edge takes part in the current query.
`timescale 1ns / 1ps
`default_nettype none
module ccc_edge_filter
    import ccc_pkg::*;
#(
    parameter int MAX_CUT = 4
) (
    input  wire vertex_t                  end_a,
    input  wire vertex_t                  end_b,
    input  wire logic [8:0]               nv,
    input  wire logic [10:0]              slot,
    input  wire slot_t [CUT_PORTS-1:0]    cuts,
    input  wire logic [2:0]               ncut,
    output logic                          live
);
    logic cut_hit;

    always_comb
    begin
        cut_hit = 1'b0;
        for (int k = 0; k < MAX_CUT; k++)
        begin
            if ((3'(k) < ncut) && ({2'b00, cuts[k]} == slot))
            begin
                cut_hit = 1'b1;
            end
        end
        live = ({1'b0, end_a} < nv) && ({1'b0, end_b} < nv) && !cut_hit;
    end
endmodule
`default_nettype wire

>>> src/cut_component_classifier_unit.sv
// Top level: edge store, union-find vertex memory and the query sequencer.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall   | action, edge_index, end_a, end_b, cuts
//   out     | output    | out_valid / out_stall | component_total, cyclic_total
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// An edge load is written straight into the edge store. A query first clears the vertex
// memory one vertex at a time, then reads each edge and, for a live one, searches the
// root of each end in the vertex memory and links the two roots when they differ,
// and ends with a root scan over all vertices; the root searches take the bulk of a query.
// Reset clears the control state; the edge store is undefined.
// The input is stalled while a query runs and while a result beat waits.
`timescale 1ns / 1ps
`default_nettype none
module cut_component_classifier_unit
    import ccc_pkg::*;
#(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 512,
    parameter int MAX_CUT      = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       action,
    input  wire logic [8:0] edge_index,
    input  wire logic [7:0] end_a,
    input  wire logic [7:0] end_b,
    input  wire logic [8:0] cut_edge_a,
    input  wire logic [8:0] cut_edge_b,
    input  wire logic [8:0] cut_edge_c,
    input  wire logic [8:0] cut_edge_d,
    input  wire logic [2:0] cut_count,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [8:0]      component_total,
    output logic [8:0]      cyclic_total,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic [9:0] cfg_data
);
    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_EREQ, S_ECHK, S_FREQ, S_FCHK, S_LINK, S_SREQ, S_SCHK, S_DONE
    } state_t;

    state_t                  state_reg;
    logic [8:0]              vcount_reg;
    logic [9:0]              ecount_reg;
    slot_t [CUT_PORTS-1:0]   cuts_reg;
    logic [2:0]              ncut_reg;
    logic [8:0]              v_reg;
    logic [10:0]             e_reg;
    logic [VAW-1:0]          x_reg;
    logic [VAW-1:0]          ra_reg;
    logic [VAW-1:0]          rb_reg;
    logic [VAW-1:0]          b_reg;
    logic                    ca_reg;
    logic                    cb_reg;
    logic                    side_reg;
    logic [8:0]              merges_reg;
    logic [8:0]              cyc_reg;
    logic                    out_valid_reg;
    logic [8:0]              comp_out_reg;
    logic [8:0]              cyc_out_reg;

    logic [15:0]             emem [MAX_EDGES];
    logic [15:0]             edata_reg;
    logic [VAW:0]            vmem [MAX_VERTICES];
    logic [VAW:0]            vdata_reg;

    logic [8:0]              nv;
    logic [10:0]             ne;
    logic [2:0]              ncut_in;
    logic [10:0]             load_idx;
    logic                    in_acc;
    logic                    live;
    logic                    vmem_we;
    logic [VAW-1:0]          vmem_waddr;
    logic [VAW:0]            vmem_wdata;
    logic                    vmem_re;
    logic [VAW-1:0]          vmem_raddr;
    logic [VAW-1:0]          vpar;
    logic                    vcyc;

    assign nv = (vcount_reg == 9'd0) ? 9'd1 :
                ({1'b0, vcount_reg} > 10'(MAX_VERTICES)) ? 9'(MAX_VERTICES) : vcount_reg;
    assign ne = ({1'b0, ecount_reg} > 11'(MAX_EDGES)) ? 11'(MAX_EDGES) : {1'b0, ecount_reg};
    assign ncut_in = (cut_count > 3'(MAX_CUT)) ? 3'(MAX_CUT) : cut_count;
    assign load_idx = {2'b00, edge_index};
    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign in_acc = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign component_total = comp_out_reg;
    assign cyclic_total = cyc_out_reg;
    assign vpar = vdata_reg[VAW:1];
    assign vcyc = vdata_reg[0];

    ccc_edge_filter #(
        .MAX_CUT (MAX_CUT)
    ) u_filter (
        .end_a (edata_reg[15:8]),
        .end_b (edata_reg[7:0]),
        .nv    (nv),
        .slot  (e_reg),
        .cuts  (cuts_reg),
        .ncut  (ncut_reg),
        .live  (live)
    );

    always_comb
    begin
        vmem_we = 1'b0;
        vmem_waddr = x_reg;
        vmem_wdata = {x_reg, 1'b0};
        vmem_re = 1'b0;
        vmem_raddr = x_reg;
        case (state_reg)
            S_CLR:
            begin
                vmem_we = 1'b1;
                vmem_waddr = v_reg[VAW-1:0];
                vmem_wdata = {v_reg[VAW-1:0], 1'b0};
            end
            S_FREQ:
            begin
                vmem_re = 1'b1;
            end
            S_FCHK:
            begin
                if ((vpar == x_reg) && side_reg)
                begin
                    vmem_we = 1'b1;
                    if (ra_reg == x_reg)
                    begin
                        vmem_waddr = x_reg;
                        vmem_wdata = {x_reg, 1'b1};
                    end
                    else
                    begin
                        vmem_waddr = ra_reg;
                        vmem_wdata = {x_reg, 1'b0};
                    end
                end
            end
            S_LINK:
            begin
                vmem_we = 1'b1;
                vmem_waddr = rb_reg;
                vmem_wdata = {rb_reg, ca_reg | cb_reg};
            end
            S_SREQ:
            begin
                vmem_re = 1'b1;
                vmem_raddr = v_reg[VAW-1:0];
            end
            default:
            begin
                vmem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (vmem_we)
        begin
            vmem[vmem_waddr] <= vmem_wdata;
        end
        if (vmem_re)
        begin
            vdata_reg <= vmem[vmem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && (action == ACT_LOAD) && (load_idx < 11'(MAX_EDGES)))
        begin
            emem[load_idx[EAW-1:0]] <= {end_a, end_b};
        end
        if (state_reg == S_EREQ)
        begin
            edata_reg <= emem[e_reg[EAW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vcount_reg <= 9'd256;
            ecount_reg <= 10'd0;
            out_valid_reg <= 1'b0;
            v_reg <= 9'd0;
            e_reg <= 11'd0;
            side_reg <= 1'b0;
            merges_reg <= 9'd0;
            cyc_reg <= 9'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_VERTEX_COUNT)
                begin
                    vcount_reg <= cfg_data[8:0];
                end
                else
                begin
                    ecount_reg <= cfg_data;
                end
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && (action == ACT_QUERY))
                    begin
                        cuts_reg <= {cut_edge_d, cut_edge_c, cut_edge_b, cut_edge_a};
                        ncut_reg <= ncut_in;
                        v_reg <= 9'd0;
                        merges_reg <= 9'd0;
                        cyc_reg <= 9'd0;
                        state_reg <= S_CLR;
                    end
                end
                S_CLR:
                begin
                    if (v_reg == nv - 9'd1)
                    begin
                        e_reg <= 11'd0;
                        state_reg <= S_EREQ;
                    end
                    else
                    begin
                        v_reg <= v_reg + 9'd1;
                    end
                end
                S_EREQ:
                begin
                    if (e_reg >= ne)
                    begin
                        v_reg <= 9'd0;
                        state_reg <= S_SREQ;
                    end
                    else
                    begin
                        state_reg <= S_ECHK;
                    end
                end
                S_ECHK:
                begin
                    if (live)
                    begin
                        x_reg <= edata_reg[8+VAW-1:8];
                        b_reg <= edata_reg[VAW-1:0];
                        side_reg <= 1'b0;
                        state_reg <= S_FREQ;
                    end
                    else
                    begin
                        e_reg <= e_reg + 11'd1;
                        state_reg <= S_EREQ;
                    end
                end
                S_FREQ:
                begin
                    state_reg <= S_FCHK;
                end
                S_FCHK:
                begin
                    if (vpar != x_reg)
                    begin
                        x_reg <= vpar;
                        state_reg <= S_FREQ;
                    end
                    else if (!side_reg)
                    begin
                        ra_reg <= x_reg;
                        ca_reg <= vcyc;
                        x_reg <= b_reg;
                        side_reg <= 1'b1;
                        state_reg <= S_FREQ;
                    end
                    else if (ra_reg == x_reg)
                    begin
                        e_reg <= e_reg + 11'd1;
                        state_reg <= S_EREQ;
                    end
                    else
                    begin
                        rb_reg <= x_reg;
                        cb_reg <= vcyc;
                        state_reg <= S_LINK;
                    end
                end
                S_LINK:
                begin
                    merges_reg <= merges_reg + 9'd1;
                    e_reg <= e_reg + 11'd1;
                    state_reg <= S_EREQ;
                end
                S_SREQ:
                begin
                    if (v_reg == nv)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SCHK;
                    end
                end
                S_SCHK:
                begin
                    if ((vpar == v_reg[VAW-1:0]) && vcyc)
                    begin
                        cyc_reg <= cyc_reg + 9'd1;
                    end
                    v_reg <= v_reg + 9'd1;
                    state_reg <= S_SREQ;
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    comp_out_reg <= nv - merges_reg;
                    cyc_out_reg <= cyc_reg;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> (state_reg == S_IDLE) && !out_valid_reg)
        else $error("input beat accepted while busy");

    a_merges_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (merges_reg < nv) && (cyc_reg <= nv - merges_reg))
        else $error("component counts out of range");

    a_vmem_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (vmem_we || vmem_re) |-> (state_reg != S_IDLE))
        else $error("vertex memory access while idle");

    a_link_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINK) |=> (state_reg == S_EREQ) && $past(ra_reg != rb_reg))
        else $error("union without distinct roots");
endmodule
`default_nettype wire
